[rtl/csvs_pkg.sv]
// ----------------------------------------------------------------------------
// csvs_pkg
// shared constants, types and helpers for the clamped spline velocity solver
// ----------------------------------------------------------------------------
`default_nettype none
package csvs_pkg;
  localparam int unsigned MaxPoints = 32;
  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned ScrAddrW = $clog2(2 * MaxPoints);

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBadInterval = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  // divider request and reply between the sequencer and the divider
  typedef struct packed {
    logic              start;
    logic signed [63:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return SatMax;
    end else if (v < -66'sd2147483648) begin
      return SatMin;
    end
    return v[31:0];
  endfunction

  // q16.16 product, truncated toward zero, saturated
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic signed [63:0] a;
    a = (p < 0) ? (p + 64'sd65535) : p;
    return sat32(66'(a >>> 16));
  endfunction
endpackage
`default_nettype wire

[rtl/csvs_ram.sv]
// ----------------------------------------------------------------------------
// csvs_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module csvs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/csvs_div.sv]
// ----------------------------------------------------------------------------
// csvs_div
// radix-2 signed divider: 64 bit dividend by 32 bit divisor, saturated q
// ----------------------------------------------------------------------------
`default_nettype none
module csvs_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire csvs_pkg::div_req_t req_i,
  output csvs_pkg::div_rsp_t      rsp_o
);
  import csvs_pkg::*;

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic [1:0]  zsgn_q, zsgn_d;
  logic        done_q, done_d;
  logic [33:0] trial;
  logic [32:0] shifted;
  logic signed [65:0] sq;

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    zero_d = zero_q;
    zsgn_d = zsgn_q;
    done_d = 1'b0;
    shifted = {rem_q[31:0], quo_q[63]};
    trial = {1'b0, shifted} - {2'b00, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = 7'd0;
      quo_d = req_i.num[63] ? 64'(-req_i.num) : req_i.num;
      rem_d = '0;
      den_d = req_i.den[31] ? 32'(-req_i.den) : req_i.den;
      neg_d = req_i.num[63] ^ req_i.den[31];
      zero_d = (req_i.den == '0);
      zsgn_d = (req_i.num == '0) ? 2'd0 : (req_i.num[63] ? 2'd2 : 2'd1);
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
    zero_q <= zero_d;
    zsgn_q <= zsgn_d;
  end

  always_comb begin
    sq = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    rsp_o.done = done_q;
    if (zero_q) begin
      rsp_o.quo = (zsgn_q == 2'd1) ? SatMax : ((zsgn_q == 2'd2) ? SatMin : '0);
    end else begin
      rsp_o.quo = sat32(sq);
    end
  end
endmodule
`default_nettype wire

[rtl/clamped_spline_velocity_solver.sv]
// ----------------------------------------------------------------------------
// clamped_spline_velocity_solver
// loads a run of waypoints, solves the clamped cubic spline for inner velocities
// ----------------------------------------------------------------------------
// Waypoints of one joint are taken one per cycle into three point memories
// until a transaction with final_point set. For runs of three or more points
// with strictly rising stamps the tridiagonal system is solved by a forward
// and a back Thomas sweep; every step reads the memories (registered read),
// and the divisions run on one shared radix-2 divider: each row needs four
// divisions, besides the row reads, setup and write-back of a forward row.
// The stamp check reads each point, and each result takes a velocity read,
// then the output register.
// While a run is solved or emitted the input is not ready. Runs of one or two
// points, runs with a non-positive interval (status 1) pass their velocities
// through; a run beyond 32 points gives a single result with status 2. All
// arithmetic is signed q16.16 and saturates.
`default_nettype none
module clamped_spline_velocity_solver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] stamp_i,
  input  wire logic [31:0] position_i,
  input  wire logic [31:0] velocity_i,
  input  wire logic        final_point_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      smoothed_velocity_o,
  output logic [1:0]       status_o,
  output logic             end_of_run_o
);
  import csvs_pkg::*;

  typedef enum logic [9:0] {
    StLoad  = 10'b0000000001,
    StCheck = 10'b0000000010,
    StRd    = 10'b0000000100,
    StCalc  = 10'b0000001000,
    StDiv   = 10'b0000010000,
    StFwdWr = 10'b0000100000,
    StBkRd  = 10'b0001000000,
    StBkWr  = 10'b0010000000,
    StEmit  = 10'b0100000000,
    StOvf   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // memories: time, position, velocity, scratch (c' low half, d' high half)
  logic              t_we, p_we, v_we, s_we;
  logic [AddrW-1:0]  t_wa, p_wa, v_wa, t_ra, p_ra, v_ra;
  logic [31:0]       t_wd, p_wd, v_wd, t_rd, p_rd, v_rd, s_wd, s_rd;
  logic [ScrAddrW-1:0] s_wa, s_ra;

  csvs_ram #(.Width(32), .Depth(MaxPoints)) u_time (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd));
  csvs_ram #(.Width(32), .Depth(MaxPoints)) u_pos (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));
  csvs_ram #(.Width(32), .Depth(MaxPoints)) u_vel (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(v_ra), .rdata_o(v_rd));
  csvs_ram #(.Width(32), .Depth(2 * MaxPoints)) u_scr (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));

  div_req_t div_req;
  div_rsp_t div_rsp;
  csvs_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // control
  logic [CntW-1:0]  cnt_q, cnt_d;        // points in run
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  idx_q, idx_d;        // sweep / emit index
  logic [3:0]       sub_q, sub_d;        // read phase within a step
  logic [1:0]       dsel_q, dsel_d;      // which division of a row
  logic [1:0]       stat_q, stat_d;
  logic             ovalid_q, ovalid_d;
  logic [31:0]      ovel_q, ovel_d;
  logic [1:0]       ostat_q, ostat_d;
  logic             oend_q, oend_d;
  logic             emit_rd_q, emit_rd_d; // read data for emit is pending

  // datapath registers
  logic [31:0]        t0_q, t1_q, t2_q;
  logic signed [31:0] p0_q, p1_q, p2_q, vf_q, vl_q, cprev_q, dprev_q, xnext_q;
  logic signed [31:0] h0_q, h1_q, sub_r_q, diag_q, sup_q, m_q, rhs_q;
  logic signed [31:0] t2r_q, t1r_q, cp_q, dpv_q;
  logic signed [31:0] t0_d2, t1_d2, t2_d2;
  logic [31:0] t0_n, t1_n, t2_n;
  logic signed [31:0] p0_n, p1_n, p2_n, vf_n, vl_n, cprev_n, dprev_n, xnext_n;
  logic signed [31:0] h0_n, h1_n, sub_r_n, diag_n, sup_n, m_n, rhs_n;
  logic signed [31:0] t2r_n, t1r_n, cp_n, dpv_n;
  logic signed [63:0] mul_a_q, mul_n;    // registered products
  logic signed [31:0] d1, d2, hh0, hh1;
  logic [CntW-1:0]    rows;
  logic               last_row;
  logic               take, out_fire;

  function automatic logic signed [31:0] ival(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return d[31] ? SatMax : $signed(d);
  endfunction

  assign rows = cnt_q - CntW'(2);
  assign last_row = (idx_q + CntW'(1) == rows);
  assign in_ready_o = (state_q == StLoad);
  assign take = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign out_valid_o = ovalid_q;
  assign smoothed_velocity_o = ovel_q;
  assign status_o = ostat_q;
  assign end_of_run_o = oend_q;
  assign d1 = sat32(66'(p1_q) - 66'(p0_q));
  assign d2 = sat32(66'(p2_q) - 66'(p1_q));
  assign hh0 = ival(t0_q, t1_q);
  assign hh1 = ival(t1_q, t2_q);
  assign t0_d2 = '0;
  assign t1_d2 = '0;
  assign t2_d2 = '0;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    idx_d = idx_q;
    sub_d = sub_q;
    dsel_d = dsel_q;
    stat_d = stat_q;
    ovalid_d = ovalid_q;
    ovel_d = ovel_q;
    ostat_d = ostat_q;
    oend_d = oend_q;
    emit_rd_d = 1'b0;
    t_we = 1'b0; p_we = 1'b0; v_we = 1'b0; s_we = 1'b0;
    t_wa = cnt_q[AddrW-1:0]; p_wa = cnt_q[AddrW-1:0]; v_wa = cnt_q[AddrW-1:0];
    t_wd = stamp_i; p_wd = position_i; v_wd = velocity_i;
    s_wa = '0; s_wd = '0;
    t_ra = '0; p_ra = '0; v_ra = '0; s_ra = '0;
    div_req = '0;
    t0_n = t0_q; t1_n = t1_q; t2_n = t2_q;
    p0_n = p0_q; p1_n = p1_q; p2_n = p2_q; vf_n = vf_q; vl_n = vl_q;
    cprev_n = cprev_q; dprev_n = dprev_q; xnext_n = xnext_q;
    h0_n = h0_q; h1_n = h1_q; sub_r_n = sub_r_q; diag_n = diag_q; sup_n = sup_q;
    m_n = m_q; rhs_n = rhs_q; t2r_n = t2r_q; t1r_n = t1r_q; cp_n = cp_q; dpv_n = dpv_q;
    mul_n = mul_a_q;
    if (out_fire) ovalid_d = 1'b0;

    case (state_q)
      StLoad: begin
        if (take) begin
          if (cnt_q < CntW'(MaxPoints)) begin
            t_we = 1'b1; p_we = 1'b1; v_we = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (final_point_i) begin
            idx_d = '0;
            sub_d = '0;
            stat_d = StatusOk;
            state_d = (ovf_q || cnt_q >= CntW'(MaxPoints)) ? StOvf : StCheck;
          end
        end
      end
      StOvf: begin
        if (!ovalid_q || out_fire) begin
          ovalid_d = 1'b1; ovel_d = '0; ostat_d = StatusOverflow; oend_d = 1'b1;
          ovf_d = 1'b0; cnt_d = '0; state_d = StLoad;
        end
      end
      // stamp check: stream times, compare neighbors
      StCheck: begin
        t_ra = idx_q[AddrW-1:0];
        sub_d = 4'd1;
        if (sub_q != 4'd0) begin
          t1_n = t_rd;
          if (idx_q > CntW'(1) && t_rd <= t1_q) stat_d = StatusBadInterval;
        end
        idx_d = idx_q + CntW'(1);
        if (idx_q == cnt_q) begin
          idx_d = '0; sub_d = '0;
          if (stat_d == StatusOk && cnt_q >= CntW'(3)) begin
            state_d = StRd;
          end else begin
            state_d = StEmit;
          end
        end
      end
      // row read: phases fetch t[r..r+2], p[r..r+2], vf, vl, c'/d' prev
      StRd: begin
        sub_d = sub_q + 4'd1;
        t_ra = AddrW'(idx_q + CntW'(sub_q));
        p_ra = AddrW'(idx_q + CntW'(sub_q));
        v_ra = (sub_q == 4'd0) ? '0 : AddrW'(cnt_q - CntW'(1));
        s_ra = (sub_q == 4'd0) ? ScrAddrW'(idx_q - CntW'(1))
                               : ScrAddrW'(MaxPoints) + ScrAddrW'(idx_q - CntW'(1));
        case (sub_q)
          4'd1: begin t0_n = t_rd; p0_n = p_rd; vf_n = v_rd; cprev_n = s_rd; end
          4'd2: begin t1_n = t_rd; p1_n = p_rd; vl_n = v_rd; dprev_n = s_rd; end
          4'd3: begin t2_n = t_rd; p2_n = p_rd; sub_d = '0; dsel_d = '0;
            state_d = StCalc; end
          default: ;
        endcase
      end
      // row setup: products and divisions, one step per phase
      StCalc: begin
        sub_d = sub_q + 4'd1;
        case (sub_q)
          4'd0: begin
            h0_n = hh0; h1_n = hh1; sub_r_n = hh1;
            sup_n = last_row ? '0 : hh0;
            diag_n = sat32(66'(2) * (66'(hh0) + 66'(hh1)));
            mul_n = 64'(d2) * 64'(hh0);
          end
          4'd1: begin
            div_req.start = 1'b1; div_req.num = mul_a_q; div_req.den = h1_q;
            dsel_d = 2'd0; state_d = StDiv;
          end
          4'd2: begin
            mul_n = 64'(d1) * 64'(h1_q);
          end
          4'd3: begin
            div_req.start = 1'b1; div_req.num = mul_a_q; div_req.den = h0_q;
            dsel_d = 2'd1; state_d = StDiv;
          end
          4'd4: begin
            rhs_n = sat32(66'(3) * (66'(t1r_q) + 66'(t2r_q)));
            mul_n = 64'(vf_q) * 64'(h1_q);
          end
          4'd5: begin
            if (idx_q == '0) rhs_n = sat32(66'(rhs_q) - 66'(qscale(mul_a_q)));
            mul_n = 64'(vl_q) * 64'(h0_q);
          end
          4'd6: begin
            if (last_row) rhs_n = sat32(66'(rhs_q) - 66'(qscale(mul_a_q)));
            mul_n = 64'(sub_r_q) * 64'(cprev_q);
          end
          4'd7: begin
            m_n = (idx_q == '0) ? diag_q : sat32(66'(diag_q) - 66'(qscale(mul_a_q)));
            mul_n = 64'(sub_r_q) * 64'(dprev_q);
          end
          4'd8: begin
            if (idx_q != '0) rhs_n = sat32(66'(rhs_q) - 66'(qscale(mul_a_q)));
          end
          4'd9: begin
            div_req.start = 1'b1; div_req.num = 64'(sup_q) <<< 16; div_req.den = m_q;
            dsel_d = 2'd2; state_d = StDiv;
          end
          4'd10: begin
            div_req.start = 1'b1; div_req.num = 64'(rhs_q) <<< 16; div_req.den = m_q;
            dsel_d = 2'd3; state_d = StDiv;
          end
          default: begin
            sub_d = '0; state_d = StFwdWr;
          end
        endcase
      end
      StDiv: begin
        if (div_rsp.done) begin
          case (dsel_q)
            2'd0: t2r_n = div_rsp.quo;
            2'd1: t1r_n = div_rsp.quo;
            2'd2: cp_n = div_rsp.quo;
            default: dpv_n = div_rsp.quo;
          endcase
          state_d = StCalc;
        end
      end
      // write c'_r then d'_r
      StFwdWr: begin
        s_we = 1'b1;
        sub_d = sub_q + 4'd1;
        if (sub_q == 4'd0) begin
          s_wa = ScrAddrW'(idx_q); s_wd = cp_q;
        end else begin
          s_wa = ScrAddrW'(MaxPoints) + ScrAddrW'(idx_q); s_wd = dpv_q;
          sub_d = '0;
          if (last_row) begin
            v_we = 1'b1; v_wa = AddrW'(idx_q + CntW'(1)); v_wd = dpv_q;
            xnext_n = dpv_q;
            if (idx_q == '0) begin
              idx_d = '0; state_d = StEmit;
            end else begin
              idx_d = idx_q - CntW'(1); state_d = StBkRd;
            end
          end else begin
            idx_d = idx_q + CntW'(1); state_d = StRd;
          end
        end
      end
      // back sweep: fetch c'_r and d'_r
      StBkRd: begin
        sub_d = sub_q + 4'd1;
        s_ra = (sub_q == 4'd0) ? ScrAddrW'(idx_q) : ScrAddrW'(MaxPoints) + ScrAddrW'(idx_q);
        case (sub_q)
          4'd1: begin cp_n = s_rd; end
          4'd2: begin dpv_n = s_rd; mul_n = 64'(cp_q) * 64'(xnext_q); end
          4'd3: begin sub_d = '0; state_d = StBkWr; end
          default: ;
        endcase
      end
      StBkWr: begin
        v_we = 1'b1; v_wa = AddrW'(idx_q + CntW'(1));
        v_wd = sat32(66'(dpv_q) - 66'(qscale(mul_a_q)));
        xnext_n = v_wd;
        if (idx_q == '0) begin
          state_d = StEmit;
        end else begin
          idx_d = idx_q - CntW'(1); state_d = StBkRd;
        end
      end
      // emit results: read velocity, hold in output register
      StEmit: begin
        v_ra = idx_q[AddrW-1:0];
        if (emit_rd_q) begin
          if (!ovalid_q || out_fire) begin
            ovalid_d = 1'b1; ovel_d = v_rd; ostat_d = stat_q;
            oend_d = (idx_q + CntW'(1) == cnt_q);
            if (idx_q + CntW'(1) == cnt_q) begin
              cnt_d = '0; idx_d = '0; state_d = StLoad;
            end else begin
              idx_d = idx_q + CntW'(1);
            end
          end else begin
            emit_rd_d = 1'b1;
          end
        end else begin
          emit_rd_d = 1'b1;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      ovalid_q <= 1'b0;
      emit_rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      ovalid_q <= ovalid_d;
      emit_rd_q <= emit_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; sub_q <= sub_d; dsel_q <= dsel_d; stat_q <= stat_d;
    ovel_q <= ovel_d; ostat_q <= ostat_d; oend_q <= oend_d;
    t0_q <= t0_n + t0_d2; t1_q <= t1_n + t1_d2; t2_q <= t2_n + t2_d2;
    p0_q <= p0_n; p1_q <= p1_n; p2_q <= p2_n; vf_q <= vf_n; vl_q <= vl_n;
    cprev_q <= cprev_n; dprev_q <= dprev_n; xnext_q <= xnext_n;
    h0_q <= h0_n; h1_q <= h1_n; sub_r_q <= sub_r_n; diag_q <= diag_n; sup_q <= sup_n;
    m_q <= m_n; rhs_q <= rhs_n; t2r_q <= t2r_n; t1r_q <= t1r_n; cp_q <= cp_n; dpv_q <= dpv_n;
    mul_a_q <= mul_n;
  end

  // input only taken while loading
  a_ready_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StLoad)) else $error("ready outside load");
  // run counter never exceeds capacity
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxPoints)) else $error("point count beyond capacity");
  // an unaccepted result is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(smoothed_velocity_o)))
    else $error("result dropped");
  // final transaction leaves load
  a_final_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && final_point_i) |=> (state_q != StLoad)) else $error("final not handled");
endmodule
`default_nettype wire
